// File: rtl/gselect_branch_predictor_top_assert.svh
// Assertion macros shared by the gselect predictor RTL.
`ifndef GSELECT_BRANCH_PREDICTOR_TOP_ASSERT_SVH
`define GSELECT_BRANCH_PREDICTOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GSBP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GSBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/gsbp_pkg.sv
// Package with the types, constants and register codes of the gselect predictor.
package gsbp_pkg;

   localparam int MAX_HISTORY_DEF = 10;
   localparam int MAX_PC_BITS_DEF = 6;

   localparam int HIST_CFG_W = 4;
   localparam int PC_CFG_W   = 3;
   localparam int PC_W       = 48;
   localparam int PC_LSB     = 2;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [HIST_CFG_W-1:0] HIST_CFG_RESET = HIST_CFG_W'(4);
   localparam logic [PC_CFG_W-1:0]   PC_CFG_RESET   = PC_CFG_W'(4);

   typedef logic [1:0] ctr_type;

   localparam ctr_type CTR_STRONG_NT = 2'b00;
   localparam ctr_type CTR_WEAK_NT   = 2'b01;
   localparam ctr_type CTR_WEAK_T    = 2'b10;
   localparam ctr_type CTR_STRONG_T  = 2'b11;

   localparam logic FUNC_PREDICT = 1'b0;
   localparam logic FUNC_UPDATE  = 1'b1;

   // Register word index, taken from paddr bit 2.
   localparam logic REG_HISTORY_BITS = 1'b0;
   localparam logic REG_PC_BITS      = 1'b1;

endpackage

// File: rtl/gselect_branch_predictor_top.sv
// Throughput: one request beat per cycle while responses are taken; the counter
// memory's single read port sets this. A stalled response holds the read stage,
// and input waits only while both are full or while the clearing pass runs.
// Reset is synchronous and active high; it resets the history and the registers.
// After reset a clearing pass writes 01 into every counter, one per cycle, all
// 2**(MAX_HISTORY+MAX_PC_BITS) of them (65536 by default), with req_tready low.
module gselect_branch_predictor_top
   import gsbp_pkg::*;
#(
   parameter int MAX_HISTORY = MAX_HISTORY_DEF,
   parameter int MAX_PC_BITS = MAX_PC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [47:0] pc, [48] actual_taken, [55:49] zero
   input  logic                  req_tuser,  // [0] func: 0 predict, 1 update
   // Response stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [0] predict_taken, [7:1] zero
   // Register port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int ADDR_W = MAX_HISTORY + MAX_PC_BITS;
   localparam int DEPTH  = 2 ** ADDR_W;
   localparam int EH_W   = $clog2(MAX_HISTORY + 1);
   localparam int EP_W   = $clog2(MAX_PC_BITS + 1);

   // Configuration registers.
   logic [HIST_CFG_W-1:0] cfg_hist_ff;
   logic [PC_CFG_W-1:0]   cfg_pc_ff;
   logic                  cfg_we;

   // Global history, only ever shifted on update beats.
   logic [MAX_HISTORY-1:0] hist_ff, hist_in;

   // Clearing pass after reset.
   logic              clr_active_ff, clr_active_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // Counter memory and its registered read data.
   ctr_type counter_mem [DEPTH];
   ctr_type rd_data_ff;

   // Read stage: the item whose counter is on rd_data_ff.
   logic              s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0] s1_idx_ff;
   logic              s1_func_ff;
   logic              s1_taken_ff;

   // Last counter write, forwarded to a read that raced it.
   logic              fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0] fwd_idx_ff;
   ctr_type           fwd_ctr_ff;

   // Response register.
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_taken_ff;

   // Index arithmetic.
   logic [EH_W-1:0]        eff_h;
   logic [EP_W-1:0]        eff_p;
   logic [MAX_HISTORY-1:0] hist_mask;
   logic [MAX_PC_BITS-1:0] row_mask;
   logic [MAX_PC_BITS-1:0] row;
   logic [ADDR_W-1:0]      req_idx;

   logic              req_func;
   logic              req_taken;
   logic              accept;
   logic              out_free;
   logic              s1_adv;
   ctr_type           ctr_cur;
   ctr_type           ctr_new;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   ctr_type           mem_wdata;

   // Terms used by the assertions.
   logic                   stall_hold;
   logic [ADDR_W:0]        s1_tag;
   logic                   upd_beat;
   logic [MAX_HISTORY-1:0] hist_spill;

   // ------------------------------------------------------------------
   // Register port. The word index comes from paddr bit 2; the two low
   // address bits are not decoded.
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_hist_ff <= HIST_CFG_RESET;
         cfg_pc_ff   <= PC_CFG_RESET;
      end else if (cfg_we) begin
         unique case (csr_paddr[2])
            REG_HISTORY_BITS: cfg_hist_ff <= csr_pwdata[HIST_CFG_W-1:0];
            REG_PC_BITS:      cfg_pc_ff   <= csr_pwdata[PC_CFG_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_HISTORY_BITS: csr_prdata = CSR_DATA_W'(cfg_hist_ff);
         REG_PC_BITS:      csr_prdata = CSR_DATA_W'(cfg_pc_ff);
      endcase
   end

   // ------------------------------------------------------------------
   // Effective widths: a register value above the supported maximum
   // saturates to it. The masks keep only the low H history bits and the
   // low P address bits.
   // ------------------------------------------------------------------
   always_comb begin
      if (int'(cfg_hist_ff) > MAX_HISTORY) begin
         eff_h = EH_W'(MAX_HISTORY);
      end else begin
         eff_h = EH_W'(cfg_hist_ff);
      end
      if (int'(cfg_pc_ff) > MAX_PC_BITS) begin
         eff_p = EP_W'(MAX_PC_BITS);
      end else begin
         eff_p = EP_W'(cfg_pc_ff);
      end
      for (int i = 0; i < MAX_HISTORY; i++) begin
         hist_mask[i] = (i < int'(eff_h));
      end
      for (int i = 0; i < MAX_PC_BITS; i++) begin
         row_mask[i] = (i < int'(eff_p));
      end
   end

   assign req_func  = req_tuser;
   assign req_taken = req_tdata[PC_W];
   assign row       = req_tdata[PC_LSB +: MAX_PC_BITS] & row_mask;

   // The row sits directly above the H history bits.
   assign req_idx = (ADDR_W'(row) << eff_h) | ADDR_W'(hist_ff & hist_mask);

   // ------------------------------------------------------------------
   // Handshakes. The read stage moves on whenever the response register
   // is empty or being emptied, and a new beat may enter in that cycle.
   // ------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !clr_active_ff && (!s1_valid_ff || out_free);
   assign accept     = req_tvalid && req_tready;

   // The history depends only on itself, the outcome and H, so it is updated
   // at acceptance; the next beat then indexes with the new history.
   always_comb begin
      hist_in = hist_ff;
      if (accept && (req_func == FUNC_UPDATE)) begin
         hist_in = MAX_HISTORY'({hist_ff, req_taken}) & hist_mask;
      end
   end

   // ------------------------------------------------------------------
   // Read, modify, write back. The memory read is registered; a write in
   // the cycle of the read is not seen by it, so the last write is kept
   // aside and wins on an index match.
   // ------------------------------------------------------------------
   assign ctr_cur = (fwd_valid_ff && (fwd_idx_ff == s1_idx_ff)) ? fwd_ctr_ff : rd_data_ff;

   always_comb begin
      ctr_new = ctr_cur;
      if (s1_taken_ff) begin
         if (ctr_cur != CTR_STRONG_T) begin
            ctr_new = ctr_cur + 2'd1;
         end
      end else begin
         if (ctr_cur != CTR_STRONG_NT) begin
            ctr_new = ctr_cur - 2'd1;
         end
      end
   end

   // The clearing pass owns the single write port until it ends.
   always_comb begin
      if (clr_active_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = CTR_WEAK_NT;
      end else begin
         mem_we    = s1_adv && (s1_func_ff == FUNC_UPDATE);
         mem_waddr = s1_idx_ff;
         mem_wdata = ctr_new;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         counter_mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         rd_data_ff <= counter_mem[req_idx];
      end
   end

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == {ADDR_W{1'b1}}) begin
            clr_active_in = 1'b0;
         end
      end
   end

   assign fwd_valid_in = fwd_valid_ff || (!clr_active_ff && mem_we);
   assign s1_valid_in  = accept || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff       <= '0;
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hist_ff       <= hist_in;
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         s1_valid_ff   <= s1_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff   <= req_idx;
         s1_func_ff  <= req_func;
         s1_taken_ff <= req_taken;
      end
      if (!clr_active_ff && mem_we) begin
         fwd_idx_ff <= mem_waddr;
         fwd_ctr_ff <= mem_wdata;
      end
      if (s1_adv) begin
         rsp_taken_ff <= ctr_cur[1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_taken_ff);

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
`include "gselect_branch_predictor_top_assert.svh"

   assign stall_hold = s1_valid_ff && rsp_valid_ff && !rsp_tready;
   assign s1_tag     = {s1_valid_ff, s1_idx_ff};
   assign upd_beat   = accept && (req_func == FUNC_UPDATE) && !cfg_we;
   assign hist_spill = hist_ff & ~hist_mask;

   // No beat may enter while the counters are still being cleared.
   `GSBP_ASSERT_NOW(a_clear_idle, clock, reset, clr_active_ff, !req_tready, "beat in clear")

   // A blocked response keeps the read stage and its index in place.
   `GSBP_ASSERT_NEXT(a_stage_holds, clock, reset, stall_hold, $stable(s1_tag), "stage lost")

   // After an update the history carries no bits above H.
   `GSBP_ASSERT_NEXT(a_hist_masked, clock, reset, upd_beat, hist_spill == '0, "history above H")

endmodule

// File: test/tb_gselect_branch_predictor_top.sv
// Self-checking testbench for the gselect branch predictor top level.
`timescale 1ns / 1ps

module tb_gselect_branch_predictor_top;
   import gsbp_pkg::*;

   // The table mirrors the largest index that the block's default sizes allow.
   localparam int STORE_DEPTH = 1 << (MAX_HISTORY_DEF + MAX_PC_BITS_DEF);
   // After reset the block clears 65536 counters with req_tready low, which is
   // the longest correct stretch without a beat; the limit is four times that.
   localparam int WATCHDOG_LIMIT = 4 * STORE_DEPTH;
   // Long receiver hold-off, far longer than the two pipeline stages can absorb.
   localparam int HOLD_OFF_CYCLES = 300;
   // Cycles allowed after the last response before a register write or the end.
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 100;
   localparam logic [PC_W-1:0] PC_ALL_ONES = '1;

   // One branch access as the testbench sees it.
   typedef struct packed {
      logic            func;
      logic [PC_W-1:0] pc;
      logic            taken;
   } branch_op_type;

   // How the outcomes of one hot branch behave within a random trace.
   typedef enum int {
      BIAS_TAKEN,
      BIAS_NOT_TAKEN,
      BIAS_ALTERNATE,
      BIAS_RANDOM
   } branch_bias_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // [47:0] pc, [48] actual_taken, [55:49] zero
   logic                  req_tuser = FUNC_PREDICT;  // [0] func
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // [0] predict_taken, [7:1] zero
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   gselect_branch_predictor_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Shadow copy of the predictor: its registers, history and counter table.
   logic [HIST_CFG_W-1:0]      hist_cfg_shadow = HIST_CFG_RESET;
   logic [PC_CFG_W-1:0]        pc_cfg_shadow   = PC_CFG_RESET;
   logic [MAX_HISTORY_DEF-1:0] global_hist_shadow = '0;
   ctr_type                    shadow_ctrs [STORE_DEPTH];

   branch_op_type pending_accesses [$];
   logic          expected_directions [$];
   int            mismatch_count = 0;

   // Driver state. The access being offered stays in current_access until its
   // beat is taken; access_held tells the stimulus process that one is in flight.
   branch_op_type current_access;
   logic          access_held = 1'b0;
   int            req_gap_left = 0;
   logic          req_burst = 1'b0;

   // Receiver state.
   int         rsp_stall_left = 0;
   logic       rsp_burst = 1'b0;
   logic       hold_armed = 1'b0;
   int         hold_count = 0;

   int         idle_cycles = 0;

   // Looks up the counter that an access selects and, for an update, trains it
   // and shifts the outcome into the history. Returns the direction that the
   // counter gave before any change.
   function automatic logic predict_and_train(input branch_op_type op);
      int unsigned h_eff;
      int unsigned p_eff;
      int unsigned h_mask;
      int unsigned row;
      int unsigned idx;
      ctr_type     ctr;
      logic        direction;
      h_eff = (hist_cfg_shadow > MAX_HISTORY_DEF) ? MAX_HISTORY_DEF : hist_cfg_shadow;
      p_eff = (pc_cfg_shadow > MAX_PC_BITS_DEF) ? MAX_PC_BITS_DEF : pc_cfg_shadow;
      h_mask = (32'd1 << h_eff) - 1;
      row = 32'(op.pc >> PC_LSB) & ((32'd1 << p_eff) - 1);
      idx = ((row << h_eff) | (32'(global_hist_shadow) & h_mask)) & (STORE_DEPTH - 1);
      ctr = shadow_ctrs[idx];
      direction = ctr[1];
      if (op.func == FUNC_UPDATE) begin
         global_hist_shadow =
            MAX_HISTORY_DEF'(((32'(global_hist_shadow) << 1) | 32'(op.taken)) & h_mask);
         if (op.taken) begin
            if (ctr != CTR_STRONG_T) ctr = ctr + 2'd1;
         end else if (ctr != CTR_STRONG_NT) begin
            ctr = ctr - 2'd1;
         end
         shadow_ctrs[idx] = ctr;
      end
      return direction;
   endfunction

   // Request driver. A fresh access is loaded only once the previous beat has
   // gone, after the gap drawn for it, so tvalid gets one assignment per edge.
   always @(posedge clock) begin : request_driver
      if (reset) begin
         req_tvalid <= 1'b0;
         access_held = 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_directions.push_back(predict_and_train(current_access));
            access_held = 1'b0;
         end
         if (!access_held) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_accesses.size() != 0) begin
               current_access = pending_accesses.pop_front();
               access_held = 1'b1;
               req_tvalid <= 1'b1;
               req_tdata <= REQ_DATA_W'({current_access.taken, current_access.pc});
               req_tuser <= current_access.func;
               // Bursts with no gaps alternate with stretches of random gaps.
               if ($urandom_range(0, 15) == 0) req_burst = ~req_burst;
               req_gap_left = req_burst ? 0 : $urandom_range(0, 11);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Every response beat is checked against the oldest
   // predicted direction; tready is then withheld for a drawn number of cycles,
   // or for the long hold-off once the stimulus arms it.
   always @(posedge clock) begin : response_monitor
      logic want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_directions.size() == 0) begin
               $error("predict_taken: expected no beat, actual %0d", rsp_tdata[0]);
               mismatch_count++;
            end else begin
               want = expected_directions.pop_front();
               if (rsp_tdata[0] !== want) begin
                  $error("predict_taken: expected %0d, actual %0d", want, rsp_tdata[0]);
                  mismatch_count++;
               end
            end
            if ($urandom_range(0, 15) == 0) rsp_burst = ~rsp_burst;
            rsp_stall_left = rsp_burst ? 0 : $urandom_range(0, 11);
         end
         if (hold_armed && hold_count < HOLD_OFF_CYCLES) begin
            hold_count++;
            rsp_tready <= 1'b0;
         end else if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Ends the run when no beat and no register write has been seen for too long.
   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("gselect_branch_predictor_top: mismatch");
            $finish;
         end
      end
   end

   task automatic push_access(input logic func, input logic [PC_W-1:0] pc, input logic taken);
      branch_op_type op;
      op.func = func;
      op.pc = pc;
      op.taken = taken;
      pending_accesses.push_back(op);
   endtask

   // Waits until every access has been taken and answered, then lets the
   // pipeline settle before the registers may change.
   task automatic wait_until_drained();
      while (pending_accesses.size() != 0 || access_held || expected_directions.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready. The bits above
   // the field are random, as the block must ignore them.
   task automatic write_register(input logic reg_sel, input logic [HIST_CFG_W-1:0] field);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom();
      if (reg_sel == REG_HISTORY_BITS) word[HIST_CFG_W-1:0] = field;
      else word[PC_CFG_W-1:0] = field[PC_CFG_W-1:0];
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({reg_sel, 2'b00});
      csr_pwdata <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (reg_sel == REG_HISTORY_BITS) hist_cfg_shadow = word[HIST_CFG_W-1:0];
      else pc_cfg_shadow = word[PC_CFG_W-1:0];
   endtask

   // Queues a trace that keeps coming back to a few hot branches, each with its
   // own outcome pattern, so that counters saturate and the history matters.
   // About three in ten accesses go to a fully random address.
   task automatic queue_branch_trace(input int count);
      logic [7:0]      hot_low [8];
      branch_bias_type bias [8];
      branch_op_type   op;
      int              pick;
      int              k;
      for (k = 0; k < 8; k++) begin
         hot_low[k] = 8'($urandom());
         bias[k] = branch_bias_type'($urandom_range(0, 3));
      end
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(0, 7);
         op.pc = PC_W'({$urandom(), $urandom()});
         if ($urandom_range(0, 9) < 7) op.pc[7:0] = hot_low[pick];
         op.func = ($urandom_range(0, 9) < 6) ? FUNC_UPDATE : FUNC_PREDICT;
         case (bias[pick])
            BIAS_TAKEN: begin
               op.taken = ($urandom_range(0, 7) != 0);
            end
            BIAS_NOT_TAKEN: begin
               op.taken = ($urandom_range(0, 7) == 0);
            end
            BIAS_ALTERNATE: begin
               op.taken = k[0];
            end
            default: begin
               op.taken = 1'($urandom_range(0, 1));
            end
         endcase
         pending_accesses.push_back(op);
      end
   endtask

   initial begin : stimulus
      int phase;
      int k;
      int unsigned hist_sel;
      int unsigned pc_sel;
      for (k = 0; k < STORE_DEPTH; k++) shadow_ctrs[k] = CTR_WEAK_NT;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset sizes (four history bits, four address bits): the address
      // extremes, and updates in both directions. These beats wait out the
      // clearing pass.
      push_access(FUNC_PREDICT, '0, 1'b0);
      push_access(FUNC_PREDICT, PC_ALL_ONES, 1'b1);
      push_access(FUNC_UPDATE, PC_ALL_ONES, 1'b1);
      push_access(FUNC_UPDATE, PC_ALL_ONES, 1'b1);
      push_access(FUNC_UPDATE, '0, 1'b0);
      push_access(FUNC_PREDICT, 48'h5555_5555_5555, 1'b0);
      push_access(FUNC_PREDICT, 48'hAAAA_AAAA_AAAA, 1'b1);
      wait_until_drained();

      // Zero widths: every access lands on the first counter and the history
      // stays clear, so the counter can be driven into both saturation limits.
      write_register(REG_HISTORY_BITS, 4'd0);
      write_register(REG_PC_BITS, 4'd0);
      repeat (3) push_access(FUNC_UPDATE, PC_ALL_ONES, 1'b1);
      push_access(FUNC_PREDICT, 48'h0000_0000_00FC, 1'b0);
      repeat (4) push_access(FUNC_UPDATE, 48'h8000_0000_0004, 1'b0);
      push_access(FUNC_PREDICT, '0, 1'b1);
      push_access(FUNC_PREDICT, PC_ALL_ONES, 1'b0);
      wait_until_drained();

      // Register values above range fall back to the widest index.
      write_register(REG_HISTORY_BITS, 4'd15);
      write_register(REG_PC_BITS, 4'd7);
      for (k = 0; k < 4; k++)
         push_access(FUNC_UPDATE, PC_W'({$urandom(), $urandom()}), k[0]);
      push_access(FUNC_PREDICT, PC_ALL_ONES, 1'b0);
      push_access(FUNC_PREDICT, '0, 1'b0);
      wait_until_drained();

      // Random traces under a range of sizes, the extremes first. During the
      // first one the receiver holds off for a long stretch while requests keep
      // coming, so the pipeline fills and req_tready must drop.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               hist_sel = MAX_HISTORY_DEF;
               pc_sel = MAX_PC_BITS_DEF;
            end
            1: begin
               hist_sel = 0;
               pc_sel = 0;
            end
            2: begin
               hist_sel = 15;
               pc_sel = 7;
            end
            default: begin
               hist_sel = $urandom_range(0, 15);
               pc_sel = $urandom_range(0, 7);
            end
         endcase
         write_register(REG_HISTORY_BITS, HIST_CFG_W'(hist_sel));
         write_register(REG_PC_BITS, HIST_CFG_W'(pc_sel));
         queue_branch_trace(ITEMS_PER_PHASE);
         if (phase == 0) hold_armed = 1'b1;
         wait_until_drained();
      end

      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (expected_directions.size() != 0)
         $error("predict_taken: %0d expected beats never arrived", expected_directions.size());
      if (mismatch_count == 0 && expected_directions.size() == 0) begin
         $display("gselect_branch_predictor_top: match");
      end else begin
         $display("gselect_branch_predictor_top: mismatch");
      end
      $finish;
   end

endmodule
